FILE: rtl/mwpd_pkg.sv
// Shared types, widths, codes and reset values for the mecanum wheel PI drive.
package mwpd_pkg;

    localparam int WHEEL_COUNT       = 4;
    localparam int POSITION_BITS_DEF = 32;

    localparam int GAIN_W     = 16;
    localparam int ROT_GAIN_W = 16;
    localparam int LIMIT_W    = 14;
    localparam int COORD_W    = 32;
    localparam int DELTA_W    = 16;
    localparam int TARGET_W   = 32;
    localparam int BIAS_W     = 32;
    localparam int ACC_W      = 15;
    localparam int MAG_W      = 14;
    localparam int DIR_W      = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_GAIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_LIMIT     = 2'd3;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST    = 16'sd0;
    localparam logic [ROT_GAIN_W-1:0]    ROTATION_GAIN_RST = 16'd40534;
    localparam logic [LIMIT_W-1:0]       PWM_LIMIT_RST     = 14'd7200;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [6:0]                pad;
        logic signed [DELTA_W-1:0] enc_delta_d;
        logic signed [DELTA_W-1:0] enc_delta_c;
        logic signed [DELTA_W-1:0] enc_delta_b;
        logic signed [DELTA_W-1:0] enc_delta_a;
        logic signed [COORD_W-1:0] target_rot;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_x;
        logic                      clear_all;
    } in_item_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_d;
        logic [DIR_W-1:0] dir_d;
        logic [MAG_W-1:0] mag_c;
        logic [DIR_W-1:0] dir_c;
        logic [MAG_W-1:0] mag_b;
        logic [DIR_W-1:0] dir_b;
        logic [MAG_W-1:0] mag_a;
        logic [DIR_W-1:0] dir_a;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic trunc;
    } mix_ctl_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic bias;
        logic diff;
        logic prod;
        logic sum;
        logic commit;
    } lane_ctl_t;

endpackage

FILE: rtl/mwpd_mixer.sv
// Mecanum mixing: turns the X, Y and rotation targets into the two wheel position targets.
module mwpd_mixer
(
    input  logic                                  clk,
    input  mwpd_pkg::mix_ctl_t                    ctl,
    input  logic signed [mwpd_pkg::COORD_W-1:0]   target_x,
    input  logic signed [mwpd_pkg::COORD_W-1:0]   target_y,
    input  logic signed [mwpd_pkg::COORD_W-1:0]   target_rot,
    input  logic [mwpd_pkg::ROT_GAIN_W-1:0]       rotation_gain,
    output logic signed [mwpd_pkg::TARGET_W-1:0]  target_plus,
    output logic signed [mwpd_pkg::TARGET_W-1:0]  target_minus
);

    localparam int SUMD_W = mwpd_pkg::COORD_W + 1;
    localparam int RG_W   = mwpd_pkg::COORD_W + mwpd_pkg::ROT_GAIN_W + 1;
    localparam int RAW_W  = SUMD_W + 17;
    localparam int FRAC_W = 24;
    localparam int TQ_W   = RAW_W - FRAC_W;

    logic signed [mwpd_pkg::COORD_W-1:0]  x_reg;
    logic signed [mwpd_pkg::COORD_W-1:0]  y_reg;
    logic signed [mwpd_pkg::COORD_W-1:0]  rot_reg;
    logic signed [SUMD_W-1:0]             dxy_reg;
    logic signed [SUMD_W-1:0]             sxy_reg;
    logic signed [RG_W-1:0]               rg_reg;
    logic signed [RG_W-1:0]               rg_next;
    logic signed [RAW_W-1:0]              raw_p_reg;
    logic signed [RAW_W-1:0]              raw_m_reg;
    logic signed [RAW_W-1:0]              raw_p_next;
    logic signed [RAW_W-1:0]              raw_m_next;
    logic signed [RAW_W-1:0]              rnd_p;
    logic signed [RAW_W-1:0]              rnd_m;
    logic signed [TQ_W-1:0]               tq_p;
    logic signed [TQ_W-1:0]               tq_m;
    logic signed [mwpd_pkg::TARGET_W-1:0] tp_reg;
    logic signed [mwpd_pkg::TARGET_W-1:0] tm_reg;

    assign rg_next = RG_W'(rot_reg) * RG_W'($signed({1'b0, rotation_gain}));

    assign raw_p_next = (RAW_W'(dxy_reg) <<< 16) + RAW_W'(rg_reg);
    assign raw_m_next = (RAW_W'(sxy_reg) <<< 16) - RAW_W'(rg_reg);

    // Truncation toward zero: negative values are biased up before the shift.
    assign rnd_p = raw_p_reg
        + $signed({{(RAW_W-FRAC_W){1'b0}}, {FRAC_W{raw_p_reg[RAW_W-1]}}});
    assign rnd_m = raw_m_reg
        + $signed({{(RAW_W-FRAC_W){1'b0}}, {FRAC_W{raw_m_reg[RAW_W-1]}}});
    assign tq_p  = TQ_W'(rnd_p >>> FRAC_W);
    assign tq_m  = TQ_W'(rnd_m >>> FRAC_W);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg   <= target_x;
            y_reg   <= target_y;
            rot_reg <= target_rot;
        end
        if (ctl.mul)
        begin
            rg_reg  <= rg_next;
            dxy_reg <= SUMD_W'(y_reg) - SUMD_W'(x_reg);
            sxy_reg <= SUMD_W'(x_reg) + SUMD_W'(y_reg);
        end
        if (ctl.add)
        begin
            raw_p_reg <= raw_p_next;
            raw_m_reg <= raw_m_next;
        end
        if (ctl.trunc)
        begin
            tp_reg <= mwpd_pkg::TARGET_W'(tq_p);
            tm_reg <= mwpd_pkg::TARGET_W'(tq_m);
        end
    end

    assign target_plus  = tp_reg;
    assign target_minus = tm_reg;

endmodule

FILE: rtl/mwpd_lane.sv
// One wheel lane: position tracking, incremental PI step, clamp and bridge code.
module mwpd_lane
#(
    parameter int POSITION_BITS = mwpd_pkg::POSITION_BITS_DEF,
    parameter bit REVERSED      = 1'b0
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mwpd_pkg::lane_ctl_t                   ctl,
    input  logic signed [mwpd_pkg::DELTA_W-1:0]   enc_delta,
    input  logic signed [mwpd_pkg::TARGET_W-1:0]  target,
    input  logic signed [mwpd_pkg::GAIN_W-1:0]    prop_gain,
    input  logic signed [mwpd_pkg::GAIN_W-1:0]    integ_gain,
    input  logic [mwpd_pkg::LIMIT_W-1:0]          pwm_limit,
    output logic [mwpd_pkg::DIR_W-1:0]            dir,
    output logic [mwpd_pkg::MAG_W-1:0]            mag
);

    localparam int EXT_W  = (POSITION_BITS > mwpd_pkg::BIAS_W) ? POSITION_BITS
                                                                : mwpd_pkg::BIAS_W;
    localparam int DIFF_W = mwpd_pkg::BIAS_W + 1;
    localparam int PROD_W = DIFF_W + mwpd_pkg::GAIN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - 8;

    logic signed [POSITION_BITS-1:0]      pos_reg;
    logic signed [POSITION_BITS-1:0]      pos_base;
    logic signed [EXT_W-1:0]              pos_ext;
    logic signed [mwpd_pkg::BIAS_W-1:0]   bias_reg;
    logic signed [mwpd_pkg::BIAS_W-1:0]   prev_reg;
    logic signed [DIFF_W-1:0]             dbias_reg;
    logic signed [PROD_W-1:0]             pprod_reg;
    logic signed [PROD_W-1:0]             iprod_reg;
    logic signed [SUM_W-1:0]              sum_reg;
    logic signed [SUM_W-1:0]              sum_next;
    logic signed [SUM_W-1:0]              rnd;
    logic signed [Q_W-1:0]                q;
    logic signed [Q_W-1:0]                lim_pos;
    logic signed [Q_W-1:0]                lim_neg;
    logic signed [Q_W-1:0]                clamped;
    logic signed [mwpd_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mwpd_pkg::ACC_W-1:0]    acc_neg;

    assign pos_base = ctl.clear ? '0 : pos_reg;
    assign pos_ext  = EXT_W'(pos_reg);

    assign sum_next = (SUM_W'(acc_reg) <<< 8) + SUM_W'(pprod_reg) + SUM_W'(iprod_reg);

    // The PI sum carries eight fraction bits; it is truncated toward zero.
    assign rnd     = sum_reg + $signed({{(SUM_W-8){1'b0}}, {8{sum_reg[SUM_W-1]}}});
    assign q       = Q_W'(rnd >>> 8);
    assign lim_pos = Q_W'($signed({1'b0, pwm_limit}));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (q > lim_pos)
            clamped = lim_pos;
        else if (q < lim_neg)
            clamped = lim_neg;
        else
            clamped = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            prev_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctl.load)
                pos_reg <= pos_base + POSITION_BITS'(enc_delta);
            if (ctl.load && ctl.clear)
            begin
                prev_reg <= '0;
                acc_reg  <= '0;
            end
            else if (ctl.commit)
            begin
                prev_reg <= bias_reg;
                acc_reg  <= mwpd_pkg::ACC_W'(clamped);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.bias)
            bias_reg <= $signed(pos_ext[mwpd_pkg::BIAS_W-1:0] - target);
        if (ctl.diff)
            dbias_reg <= DIFF_W'(bias_reg) - DIFF_W'(prev_reg);
        if (ctl.prod)
        begin
            pprod_reg <= PROD_W'(prop_gain) * PROD_W'(dbias_reg);
            iprod_reg <= PROD_W'(integ_gain) * PROD_W'(bias_reg);
        end
        if (ctl.sum)
            sum_reg <= sum_next;
    end

    assign acc_neg = -acc_reg;

    always_comb
    begin
        if (acc_reg == '0)
        begin
            dir = mwpd_pkg::DIR_STOP;
            mag = '0;
        end
        else if (!acc_reg[mwpd_pkg::ACC_W-1])
        begin
            dir = REVERSED ? mwpd_pkg::DIR_REV : mwpd_pkg::DIR_FWD;
            mag = acc_reg[mwpd_pkg::MAG_W-1:0];
        end
        else
        begin
            dir = REVERSED ? mwpd_pkg::DIR_FWD : mwpd_pkg::DIR_REV;
            mag = acc_neg[mwpd_pkg::MAG_W-1:0];
        end
    end

endmodule

FILE: rtl/mecanum_wheel_pi_drive.sv
// Top level of the mecanum four-wheel incremental PI position drive.
// Each input item is one control tick and produces exactly one result item with a
// bridge direction code and a magnitude for each of the four wheels. The shared
// mixer forms the wheel targets in three steps (rotation multiply, add, truncate),
// then the four wheel lanes run the PI update side by side in five steps (bias,
// bias change, gain multiplies, sum, truncate and clamp), and the result is merged
// into the output register. The block takes no new item until the last one has run
// through these steps and its result is in the output register; the output step waits
// while an earlier result still stalls there unaccepted. The
// next item is accepted while a finished result still waits in the output register.
module mecanum_wheel_pi_drive
#(
    parameter int POSITION_BITS = mwpd_pkg::POSITION_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // clear_all, target_x, target_y, target_rot, enc_delta_a..enc_delta_d, zero fill
    input  logic [mwpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dir_a, mag_a, dir_b, mag_b, dir_c, mag_c, dir_d, mag_d
    output logic [mwpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [mwpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mwpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_TRUNC = 4'd3;
    localparam logic [3:0] ST_BIAS  = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_PROD  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_CLAMP = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam int WC = mwpd_pkg::WHEEL_COUNT;

    logic [3:0]                            state_reg;
    logic [3:0]                            state_next;
    logic signed [mwpd_pkg::GAIN_W-1:0]    prop_gain_reg;
    logic signed [mwpd_pkg::GAIN_W-1:0]    integ_gain_reg;
    logic [mwpd_pkg::ROT_GAIN_W-1:0]       rotation_gain_reg;
    logic [mwpd_pkg::LIMIT_W-1:0]          pwm_limit_reg;
    logic                                  out_valid_reg;
    mwpd_pkg::out_item_t                   out_reg;
    mwpd_pkg::out_item_t                   out_next;
    mwpd_pkg::in_item_t                    in_item;
    mwpd_pkg::mix_ctl_t                    mix_ctl;
    mwpd_pkg::lane_ctl_t                   lane_ctl;
    logic                                  accept;
    logic                                  out_load;
    logic signed [mwpd_pkg::TARGET_W-1:0]  target_plus;
    logic signed [mwpd_pkg::TARGET_W-1:0]  target_minus;
    logic signed [mwpd_pkg::DELTA_W-1:0]   delta_arr  [WC];
    logic signed [mwpd_pkg::TARGET_W-1:0]  target_arr [WC];
    logic [mwpd_pkg::DIR_W-1:0]            dir_arr    [WC];
    logic [mwpd_pkg::MAG_W-1:0]            mag_arr    [WC];

    assign in_item       = mwpd_pkg::in_item_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= mwpd_pkg::PROP_GAIN_RST;
            integ_gain_reg    <= mwpd_pkg::INTEG_GAIN_RST;
            rotation_gain_reg <= mwpd_pkg::ROTATION_GAIN_RST;
            pwm_limit_reg     <= mwpd_pkg::PWM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mwpd_pkg::REG_PROP_GAIN:     prop_gain_reg     <= $signed(cfg_data);
                mwpd_pkg::REG_INTEG_GAIN:    integ_gain_reg    <= $signed(cfg_data);
                mwpd_pkg::REG_ROTATION_GAIN: rotation_gain_reg <= cfg_data;
                mwpd_pkg::REG_PWM_LIMIT:
                    pwm_limit_reg <= cfg_data[mwpd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_TRUNC;
            ST_TRUNC: state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mix_ctl.load    = accept;
        mix_ctl.mul     = (state_reg == ST_MUL);
        mix_ctl.add     = (state_reg == ST_ADD);
        mix_ctl.trunc   = (state_reg == ST_TRUNC);
        lane_ctl.load   = accept;
        lane_ctl.clear  = in_item.clear_all;
        lane_ctl.bias   = (state_reg == ST_BIAS);
        lane_ctl.diff   = (state_reg == ST_DIFF);
        lane_ctl.prod   = (state_reg == ST_PROD);
        lane_ctl.sum    = (state_reg == ST_SUM);
        lane_ctl.commit = (state_reg == ST_CLAMP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    mwpd_mixer u_mixer
    (
        .clk           (clk),
        .ctl           (mix_ctl),
        .target_x      (in_item.target_x),
        .target_y      (in_item.target_y),
        .target_rot    (in_item.target_rot),
        .rotation_gain (rotation_gain_reg),
        .target_plus   (target_plus),
        .target_minus  (target_minus)
    );

    assign delta_arr[0]  = in_item.enc_delta_a;
    assign delta_arr[1]  = in_item.enc_delta_b;
    assign delta_arr[2]  = in_item.enc_delta_c;
    assign delta_arr[3]  = in_item.enc_delta_d;
    assign target_arr[0] = target_plus;
    assign target_arr[1] = target_minus;
    assign target_arr[2] = target_minus;
    assign target_arr[3] = target_plus;

    for (genvar w = 0; w < WC; w++)
    begin : g_lane
        mwpd_lane
        #(
            .POSITION_BITS (POSITION_BITS),
            .REVERSED      (w == WC - 1)
        )
        u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .enc_delta  (delta_arr[w]),
            .target     (target_arr[w]),
            .prop_gain  (prop_gain_reg),
            .integ_gain (integ_gain_reg),
            .pwm_limit  (pwm_limit_reg),
            .dir        (dir_arr[w]),
            .mag        (mag_arr[w])
        );
    end

    always_comb
    begin
        out_next.dir_a = dir_arr[0];
        out_next.mag_a = mag_arr[0];
        out_next.dir_b = dir_arr[1];
        out_next.mag_b = mag_arr[1];
        out_next.dir_c = dir_arr[2];
        out_next.mag_c = mag_arr[2];
        out_next.dir_d = dir_arr[3];
        out_next.mag_d = mag_arr[3];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mwpd_pkg::OUT_DATA_W'(out_reg);

`ifndef SYNTHESIS
    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in flight");

    a_mag_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_reg.mag_a <= pwm_limit_reg && out_reg.mag_b <= pwm_limit_reg
            && out_reg.mag_c <= pwm_limit_reg && out_reg.mag_d <= pwm_limit_reg)
        else $error("drive magnitude beyond the clamp");

    a_stop_iff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_reg.dir_a == mwpd_pkg::DIR_STOP) == (out_reg.mag_a == '0))
            && ((out_reg.dir_d == mwpd_pkg::DIR_STOP) == (out_reg.mag_d == '0)))
        else $error("stop code and zero magnitude disagree");
`endif

endmodule
